@@ hw/rtl/psab_pkg.sv @@
// Shared types, constants and helpers for the pixel store with alpha blend.
// Used by every module of the block; depends on nothing.
package psab_pkg;

   // frame limits and store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int DIM_BITS   = 9;
   localparam int COORD_BITS = 16;
   localparam int CHAN_BITS  = 8;
   localparam int PROD_BITS  = COORD_BITS + DIM_BITS;

   // access codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_BLEND = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      pixel_type            data;
   } ram_wr_type;

   // exact floor(s / 255) for s up to 255 * 255
   function automatic logic [CHAN_BITS-1:0] div255(input logic [2*CHAN_BITS-1:0] s);
      logic [2*CHAN_BITS:0] t;
      t = {1'b0, s} + (2*CHAN_BITS+1)'(1) + (2*CHAN_BITS+1)'(s >> CHAN_BITS);
      return t[2*CHAN_BITS-1:CHAN_BITS];
   endfunction

endpackage

@@ hw/rtl/psab_pixel_ram.sv @@
// Single-port-write, registered-read pixel memory of the frame store.
// Depends on psab_pkg for geometry and the write beat type.
module psab_pixel_ram (
   input  logic                       clock,
   input  psab_pkg::ram_wr_type       wr,
   input  logic [psab_pkg::ADDR_BITS-1:0] rd_addr,
   output psab_pkg::pixel_type        rd_data
);
   import psab_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   // write one entry per cycle while wr.en is high
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // register the read every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/psab_blend.sv @@
// Per-channel alpha mix: weighted sum registered, then floor division by 255.
// Depends on psab_pkg for the pixel type and div255.
module psab_blend (
   input  logic                           clock,
   input  psab_pkg::pixel_type            src,
   input  psab_pkg::pixel_type            dst,
   input  logic [psab_pkg::CHAN_BITS-1:0] alpha,
   output psab_pkg::pixel_type            mixed
);
   import psab_pkg::*;

   localparam int SUM_BITS = 2 * CHAN_BITS;

   logic [CHAN_BITS-1:0] alpha_inv;
   logic [SUM_BITS-1:0]  sum_red_in,   sum_red_ff;
   logic [SUM_BITS-1:0]  sum_green_in, sum_green_ff;
   logic [SUM_BITS-1:0]  sum_blue_in,  sum_blue_ff;

   assign alpha_inv = ~alpha;

   // weighted sums; the total never exceeds 255 * 255
   always_comb begin
      sum_red_in   = SUM_BITS'(src.red)   * SUM_BITS'(alpha)
                   + SUM_BITS'(dst.red)   * SUM_BITS'(alpha_inv);
      sum_green_in = SUM_BITS'(src.green) * SUM_BITS'(alpha)
                   + SUM_BITS'(dst.green) * SUM_BITS'(alpha_inv);
      sum_blue_in  = SUM_BITS'(src.blue)  * SUM_BITS'(alpha)
                   + SUM_BITS'(dst.blue)  * SUM_BITS'(alpha_inv);
   end

   // hold the sums for the divide stage
   always_ff @(posedge clock) begin
      sum_red_ff   <= sum_red_in;
      sum_green_ff <= sum_green_in;
      sum_blue_ff  <= sum_blue_in;
   end

   // divide by 255 through the reciprocal shift form
   always_comb begin
      mixed.red   = div255(sum_red_ff);
      mixed.green = div255(sum_green_ff);
      mixed.blue  = div255(sum_blue_ff);
   end

endmodule

@@ hw/rtl/pixel_store_alpha_blend.sv @@
// Top level of the RGB888 pixel store with read, write and alpha blend.
// Depends on psab_pkg, psab_pixel_ram and psab_blend.
//
// Usage: after reset the block sweeps the 65536-entry pixel memory to black, one
// entry per cycle, and holds busy high for the whole sweep; frame_width and
// frame_height writes are taken at any time. An access is taken when start is
// high and busy is low. Each access runs through these steps in order: register
// the beat, form y*width+x, the memory read, the weighted sums, and the divide
// by 255 with write-back. The result beat shows on the rsp_ ports for exactly
// one cycle with rsp_valid high, and busy is already low in that cycle; a new
// access is taken only once the last one is through. The receiver cannot stall
// results; it must take each beat in the cycle that rsp_valid is high.
module pixel_store_alpha_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  logic signed [psab_pkg::COORD_BITS-1:0] req_x_coord,
   input  logic signed [psab_pkg::COORD_BITS-1:0] req_y_coord,
   input  logic [psab_pkg::CHAN_BITS-1:0]      req_red_in,
   input  logic [psab_pkg::CHAN_BITS-1:0]      req_green_in,
   input  logic [psab_pkg::CHAN_BITS-1:0]      req_blue_in,
   input  logic [psab_pkg::CHAN_BITS-1:0]      req_alpha_in,
   output logic                                rsp_valid,
   output logic [psab_pkg::CHAN_BITS-1:0]      rsp_red_out,
   output logic [psab_pkg::CHAN_BITS-1:0]      rsp_green_out,
   output logic [psab_pkg::CHAN_BITS-1:0]      rsp_blue_out,
   output logic                                rsp_in_range,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [psab_pkg::DIM_BITS-1:0]       csr_wr_data
);
   import psab_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_MIX   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] clear_ff, clear_in;
   logic [DIM_BITS-1:0]  frame_width_ff, frame_height_ff;
   logic [DIM_BITS-1:0]  width_eff, height_eff;

   logic [1:0]            op_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   pixel_type             src_ff;
   logic [CHAN_BITS-1:0]  alpha_ff;

   logic                  inside_in, inside_ff;
   logic [PROD_BITS-1:0]  lin_addr;
   logic [ADDR_BITS-1:0]  addr_ff;

   ram_wr_type            wr;
   pixel_type             dst;
   pixel_type             mixed;
   pixel_type             px_in;

   logic                  rsp_valid_ff;
   pixel_type             rsp_px_ff;
   logic                  rsp_in_range_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_BITS'(MAX_WIDTH);
         frame_height_ff <= DIM_BITS'(MAX_HEIGHT);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // saturate the frame to the store size
   assign width_eff  = (frame_width_ff  > DIM_BITS'(MAX_WIDTH))  ? DIM_BITS'(MAX_WIDTH)
                                                                : frame_width_ff;
   assign height_eff = (frame_height_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT)
                                                                : frame_height_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + ADDR_BITS'(1);
            if (clear_ff == {ADDR_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE:  if (start) state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_READ;
         ST_READ:  state_in = ST_MIX;
         ST_MIX:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // capture the request beat
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff      <= req_opcode;
         x_ff       <= req_x_coord;
         y_ff       <= req_y_coord;
         src_ff     <= '{red: req_red_in, green: req_green_in, blue: req_blue_in};
         alpha_ff   <= req_alpha_in;
      end
   end

   // range check and row-major address
   always_comb begin
      inside_in = !x_ff[COORD_BITS-1] && !y_ff[COORD_BITS-1]
               && (x_ff < COORD_BITS'(width_eff)) && (y_ff < COORD_BITS'(height_eff));
      lin_addr  = PROD_BITS'(y_ff) * PROD_BITS'(width_eff) + PROD_BITS'(x_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR) begin
         inside_ff <= inside_in;
         addr_ff   <= lin_addr[ADDR_BITS-1:0];
      end
   end

   psab_pixel_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (addr_ff),
      .rd_data (dst)
   );

   psab_blend u_blend (
      .clock (clock),
      .src   (src_ff),
      .dst   (dst),
      .alpha (alpha_ff),
      .mixed (mixed)
   );

   // pick the pixel after the access
   always_comb begin
      priority if (!inside_ff) begin
         px_in = '0;
      end else if (op_ff == OP_WRITE) begin
         px_in = src_ff;
      end else if (op_ff == OP_BLEND) begin
         px_in = mixed;
      end else begin
         px_in = dst;
      end
   end

   // write back: clearing sweep or the modified pixel
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr.en   = 1'b1;
         wr.addr = clear_ff;
         wr.data = '0;
      end else begin
         wr.en   = (state_ff == ST_DIV) && inside_ff
                && ((op_ff == OP_WRITE) || (op_ff == OP_BLEND));
         wr.addr = addr_ff;
         wr.data = px_in;
      end
   end

   // result beat, one cycle wide
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DIV);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         rsp_px_ff       <= px_in;
         rsp_in_range_ff <= inside_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_px_ff.red;
   assign rsp_green_out = rsp_px_ff.green;
   assign rsp_blue_out  = rsp_px_ff.blue;
   assign rsp_in_range  = rsp_in_range_ff;

`ifndef SYNTH
   // a result beat follows only the divide step
   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_DIV))
      else $error("result beat without a finished access");

   // result beats never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result beat repeated");

   // an out-of-range result carries black
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_in_range_ff) |-> (rsp_px_ff == '0))
      else $error("out-of-range result not black");

   // memory is written only by the sweep or the write-back step
   a_wr_source: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> ((state_ff == ST_CLEAR) || (state_ff == ST_DIV)))
      else $error("stray memory write");

   // the block is idle when a result beat shows
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("busy while result beat shows");
`endif

endmodule

@@ sim/tb_pixel_store_alpha_blend.sv @@
// Self-checking testbench for pixel_store_alpha_blend: directed table, then random accesses
// over several frame sizes, each result checked against a table value or a pixel-store shadow model.
// Depends on psab_pkg and the pixel_store_alpha_blend RTL.
module tb_pixel_store_alpha_blend;
   import psab_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 11;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int TAIL_CYCLES   = 12;
   localparam int MAX_SHOWN     = 10;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int PHASES        = 8;

   // codes the package leaves unnamed
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [1:0]                   opcode;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      pixel_type                    color;
      logic [CHAN_BITS-1:0]         alpha;
   } access_type;

   typedef struct {
      pixel_type color;
      logic      in_range;
   } pixel_result_type;

   typedef struct {
      access_type       acc;
      bit               given;
      pixel_result_type want;
   } table_row_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_opcode;
   logic signed [COORD_BITS-1:0] req_x_coord;
   logic signed [COORD_BITS-1:0] req_y_coord;
   logic [CHAN_BITS-1:0]         req_red_in;
   logic [CHAN_BITS-1:0]         req_green_in;
   logic [CHAN_BITS-1:0]         req_blue_in;
   logic [CHAN_BITS-1:0]         req_alpha_in;
   logic                         rsp_valid;
   logic [CHAN_BITS-1:0]         rsp_red_out;
   logic [CHAN_BITS-1:0]         rsp_green_out;
   logic [CHAN_BITS-1:0]         rsp_blue_out;
   logic                         rsp_in_range;
   logic                         csr_wr_en;
   logic [1:0]                   csr_index;
   logic [DIM_BITS-1:0]          csr_wr_data;

   // shadow of the block: pixel store and frame registers
   pixel_type           shadow_frame [DEPTH];
   logic [DIM_BITS-1:0] shadow_width;
   logic [DIM_BITS-1:0] shadow_height;

   pixel_result_type pending_pixels[$];
   table_row_type    directed_rows[$];
   int               fault_count = 0;
   int               burst_left;

   pixel_store_alpha_blend u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_in_range  (rsp_in_range),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD/2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("Some tests failed");
      $finish;
   end

   function automatic int frame_span(logic [DIM_BITS-1:0] reg_value, int limit);
      return (int'(reg_value) > limit) ? limit : int'(reg_value);
   endfunction

   function automatic int blend_channel(logic [CHAN_BITS-1:0] src, logic [CHAN_BITS-1:0] dst,
                                        logic [CHAN_BITS-1:0] alpha);
      int s, d, a;
      s = int'(src);
      d = int'(dst);
      a = int'(alpha);
      return (s * a + d * (255 - a)) / 255;
   endfunction

   // apply one access to the shadow store and return the pixel it reports
   function automatic pixel_result_type predict_access(access_type acc);
      pixel_result_type res;
      pixel_type        px;
      int               w, h, xu, yu, addr;
      w  = frame_span(shadow_width, MAX_WIDTH);
      h  = frame_span(shadow_height, MAX_HEIGHT);
      xu = int'({1'b0, acc.x});
      yu = int'({1'b0, acc.y});
      res.color    = '0;
      res.in_range = 1'b0;
      if (!acc.x[COORD_BITS-1] && !acc.y[COORD_BITS-1] && xu < w && yu < h) begin
         addr = yu * w + xu;
         px   = shadow_frame[ADDR_BITS'(addr)];
         if (acc.opcode == OP_WRITE) begin
            px = acc.color;
         end else if (acc.opcode == OP_BLEND) begin
            px.red   = CHAN_BITS'(blend_channel(acc.color.red, px.red, acc.alpha));
            px.green = CHAN_BITS'(blend_channel(acc.color.green, px.green, acc.alpha));
            px.blue  = CHAN_BITS'(blend_channel(acc.color.blue, px.blue, acc.alpha));
         end
         shadow_frame[ADDR_BITS'(addr)] = px;
         res.color    = px;
         res.in_range = 1'b1;
      end
      return res;
   endfunction

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= MAX_SHOWN) $display("%s", msg);
   endtask

   // write one register; call at a falling edge, returns at a falling edge
   task automatic write_csr(logic [1:0] index, logic [DIM_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_FRAME_WIDTH) shadow_width = data;
      else if (index == CSR_FRAME_HEIGHT) shadow_height = data;
      @(negedge clock);
   endtask

   // present one beat, hold it until taken, queue its expected pixel
   task automatic send_access(access_type acc, bit given, pixel_result_type want);
      pixel_result_type predicted;
      start        <= 1'b1;
      req_opcode   <= acc.opcode;
      req_x_coord  <= acc.x;
      req_y_coord  <= acc.y;
      req_red_in   <= acc.color.red;
      req_green_in <= acc.color.green;
      req_blue_in  <= acc.color.blue;
      req_alpha_in <= acc.alpha;
      do @(posedge clock); while (busy);
      predicted = predict_access(acc);
      pending_pixels.push_back(given ? want : predicted);
      @(negedge clock);
   endtask

   // keep start high inside a burst, drop it for a random gap between bursts
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(3, 0) == 0) ? $urandom_range(30, 0) : $urandom_range(7, 0);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(8, 0);
      end
   endtask

   // drop start and wait for every queued pixel, then let the pipeline settle
   task automatic drain_pixels();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic add_row(logic [1:0] op, int x, int y, logic [23:0] rgb,
                          logic [7:0] alpha, bit given, logic [23:0] want_rgb,
                          logic want_in);
      table_row_type row;
      row.acc.opcode     = op;
      row.acc.x          = COORD_BITS'(x);
      row.acc.y          = COORD_BITS'(y);
      row.acc.color      = rgb;
      row.acc.alpha      = alpha;
      row.given          = given;
      row.want.color     = want_rgb;
      row.want.in_range  = want_in;
      directed_rows.push_back(row);
   endtask

   // mostly inside the frame, some on the border, some negative, some anywhere
   function automatic logic signed [COORD_BITS-1:0] pick_coord(int span);
      int kind;
      kind = $urandom_range(99, 0);
      if (span == 0 || kind < 10) return COORD_BITS'($urandom);
      if (kind < 14) return COORD_BITS'(-$urandom_range(4, 1));
      if (kind < 24) return COORD_BITS'(span - $urandom_range(1, 0));
      return COORD_BITS'($urandom_range(span - 1, 0));
   endfunction

   function automatic access_type make_access(access_type prev);
      access_type acc;
      int         pick;
      pick = $urandom_range(99, 0);
      if (pick < 30)      acc.opcode = OP_WRITE;
      else if (pick < 65) acc.opcode = OP_BLEND;
      else if (pick < 95) acc.opcode = OP_READ;
      else                acc.opcode = OP_UNUSED;
      // revisit the last pixel often so blends stack on one another
      if ($urandom_range(3, 0) == 0) begin
         acc.x = prev.x;
         acc.y = prev.y;
      end else begin
         acc.x = pick_coord(frame_span(shadow_width, MAX_WIDTH));
         acc.y = pick_coord(frame_span(shadow_height, MAX_HEIGHT));
      end
      acc.color = pixel_type'($urandom);
      pick = $urandom_range(9, 0);
      if (pick == 0)      acc.alpha = 8'h00;
      else if (pick == 1) acc.alpha = 8'hFF;
      else                acc.alpha = CHAN_BITS'($urandom);
      return acc;
   endfunction

   // check every result beat against the oldest expectation
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            note_fault($sformatf("unexpected result beat: rgb %02h%02h%02h in_range %0b",
                                 rsp_red_out, rsp_green_out, rsp_blue_out, rsp_in_range));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_red_out !== want.color.red || rsp_green_out !== want.color.green ||
                rsp_blue_out !== want.color.blue || rsp_in_range !== want.in_range) begin
               note_fault($sformatf(
                  "result mismatch: expected rgb %02h%02h%02h in_range %0b, got %02h%02h%02h %0b",
                  want.color.red, want.color.green, want.color.blue, want.in_range,
                  rsp_red_out, rsp_green_out, rsp_blue_out, rsp_in_range));
            end
         end
      end
   end

   initial begin
      int                  phase_widths  [PHASES];
      int                  phase_heights [PHASES];
      access_type          acc;
      pixel_result_type    none;
      int                  per_phase;

      reset        = 1'b1;
      start        = 1'b0;
      req_opcode   = OP_READ;
      req_x_coord  = '0;
      req_y_coord  = '0;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      req_alpha_in = '0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_FRAME_WIDTH;
      csr_wr_data  = '0;
      burst_left   = 0;
      none         = '{color: '0, in_range: 1'b0};
      acc          = '{opcode: OP_READ, x: '0, y: '0, color: '0, alpha: '0};
      for (int i = 0; i < DEPTH; i++) shadow_frame[ADDR_BITS'(i)] = '0;
      shadow_width  = DIM_BITS'(MAX_WIDTH);
      shadow_height = DIM_BITS'(MAX_HEIGHT);

      // frame sizes: single pixel, single row, single column, empty, saturated, odd, full
      phase_widths  = '{1, 256, 1, 0, 511, 17, 5, 256};
      phase_heights = '{1, 1, 256, 12, 300, 9, 0, 256};

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed table on the reset frame (256 x 256, all black)
      add_row(OP_READ,       0,      0, 24'h000000, 8'h00, 1'b1, 24'h000000, 1'b1);
      add_row(OP_READ,     255,    255, 24'h000000, 8'h00, 1'b1, 24'h000000, 1'b1);
      add_row(OP_WRITE,      0,      0, 24'hFFFFFF, 8'h00, 1'b1, 24'hFFFFFF, 1'b1);
      add_row(OP_WRITE,    255,    255, 24'h123456, 8'h00, 1'b1, 24'h123456, 1'b1);
      add_row(OP_BLEND,      0,      0, 24'h000000, 8'h00, 1'b0, 24'h000000, 1'b0);
      add_row(OP_BLEND,      0,      0, 24'h0040FF, 8'hFF, 1'b0, 24'h000000, 1'b0);
      add_row(OP_BLEND,    255,    255, 24'h808080, 8'h80, 1'b0, 24'h000000, 1'b0);
      add_row(OP_UNUSED,   255,    255, 24'hFFFFFF, 8'hFF, 1'b0, 24'h000000, 1'b0);
      add_row(OP_WRITE,    255,      0, 24'hA55AC3, 8'h00, 1'b1, 24'hA55AC3, 1'b1);
      add_row(OP_WRITE,      0,    255, 24'h3CC30F, 8'h00, 1'b1, 24'h3CC30F, 1'b1);
      add_row(OP_WRITE,    256,      0, 24'hFFFFFF, 8'h00, 1'b1, 24'h000000, 1'b0);
      add_row(OP_WRITE,      0,    256, 24'hFFFFFF, 8'h00, 1'b1, 24'h000000, 1'b0);
      add_row(OP_READ,      -1,      0, 24'h000000, 8'h00, 1'b1, 24'h000000, 1'b0);
      add_row(OP_BLEND,      5, -32768, 24'hFFFFFF, 8'hFF, 1'b1, 24'h000000, 1'b0);
      add_row(OP_READ,   32767,  32767, 24'h000000, 8'h00, 1'b1, 24'h000000, 1'b0);
      add_row(OP_WRITE, -32768, -32768, 24'hFFFFFF, 8'h00, 1'b1, 24'h000000, 1'b0);
      add_row(OP_READ,       0,      0, 24'h000000, 8'h00, 1'b0, 24'h000000, 1'b0);
      add_row(OP_WRITE,     10,     10, 24'h4080C0, 8'h00, 1'b1, 24'h4080C0, 1'b1);
      add_row(OP_BLEND,     10,     10, 24'hFF007F, 8'h77, 1'b0, 24'h000000, 1'b0);
      add_row(OP_BLEND,     10,     10, 24'h01FE80, 8'hC8, 1'b0, 24'h000000, 1'b0);
      add_row(OP_READ,      10,     10, 24'h000000, 8'h00, 1'b0, 24'h000000, 1'b0);
      add_row(OP_BLEND,     11,     10, 24'hFFFFFF, 8'hFF, 1'b0, 24'h000000, 1'b0);

      foreach (directed_rows[i]) begin
         send_access(directed_rows[i].acc, directed_rows[i].given, directed_rows[i].want);
         pace_sender();
      end
      drain_pixels();

      // random phases, each on its own frame size, store kept across phases
      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_FRAME_WIDTH,  DIM_BITS'(phase_widths[p]));
         write_csr(CSR_FRAME_HEIGHT, DIM_BITS'(phase_heights[p]));
         write_csr((p % 2 == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, DIM_BITS'($urandom));
         repeat (per_phase) begin
            acc = make_access(acc);
            send_access(acc, 1'b0, none);
            pace_sender();
         end
         drain_pixels();
      end

      if (fault_count == 0 && pending_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
